/* design/ntpsws_pkg.sv */
package ntpsws_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned STAT_W    = 48;
  localparam int unsigned DISP_W    = 32;
  localparam int unsigned MEAN_W    = 52;
  localparam int unsigned ACC_W     = 100;
  localparam int unsigned ROOT_W    = 50;
  localparam int unsigned SREM_W    = 52;
  localparam int unsigned STEP_W    = 7;
  localparam int unsigned MDIV_STEPS = 52;
  localparam int unsigned VDIV_STEPS = 100;
  localparam int unsigned SQRT_STEPS = 50;
  localparam logic [STAT_W-1:0] MAX48 = {STAT_W{1'b1}};

  localparam logic [1:0] CLASS_SYNC = 2'd0;
  localparam logic [1:0] CLASS_ZERO = 2'd1;
  localparam logic [1:0] CLASS_BAD  = 2'd2;

  typedef struct packed {
    logic              load_in;
    logic              diff;
    logic              push;
    logic              clear;
    logic              sum_step;
    logic              mdiv_step;
    logic              sq_step;
    logic              vdiv_step;
    logic              sqrt_step;
    logic              finish;
    logic [STEP_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic             sync;
    logic [CNT_W-1:0] n;
    logic             out_free;
  } status_t;

  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  // One restoring division step: returns the quotient bit above the new remainder.
  function automatic logic [4:0] div_step(input logic [3:0] rem, input logic bit_in,
                                          input logic [4:0] den);
    logic [4:0] trial;
    logic [4:0] res;
    trial = {rem, bit_in};
    if (trial >= den) begin
      res = {1'b1, 4'(trial - den)};
    end else begin
      res = {1'b0, trial[3:0]};
    end
    return res;
  endfunction

  // One digit of the bitwise integer square root, two radicand bits per step.
  function automatic sqrt_t sqrt_step(input sqrt_t cur, input logic [1:0] bits);
    logic [SREM_W+1:0] part;
    logic [SREM_W+1:0] trial;
    sqrt_t res;
    part  = {cur.rem, bits};
    trial = {2'b00, cur.root, 2'b01};
    if (part >= trial) begin
      res.rem  = SREM_W'(part - trial);
      res.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = SREM_W'(part);
      res.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

/* design/ntp_sample_window_statistics.sv */
// NTP sample window statistics.
// Input stream: one request per NTP response. s_axis_tdata carries T1..T4,
// the raw root dispersion and the stratum. Output stream: one result per
// request with means, sample standard deviations, the uncertainty sum and
// the number of samples held in the last 16-entry window.
// A response with stratum 0 or 16 and above is answered with no statistics
// and empties the window. A valid response runs through the serial mean
// divider, the shared 24x24 squaring multiplier, the serial variance divider
// and the bitwise square root; a single sample stops after the mean divider.
// One request is in flight at a time: no new request is taken until the
// processing of the last one is done.
// The result sits in an output register: a new request is taken while it
// waits, and processing holds in its last step until the receiver takes it.
// After reset the window is empty and no result is pending.
module ntp_sample_window_statistics (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // Fields from bit 0: client_send_time, server_receive_time, server_send_time,
  // client_receive_time, root_dispersion_raw, stratum_in.
  input  logic [295:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // Fields from bit 0: stratum_echo, transmit_seconds, mean_offset, mean_delay,
  // mean_root_dispersion, delay_spread, offset_jitter, uncertainty, sample_count.
  output logic [319:0] m_axis_tdata_o,
  // Fields from bit 0: synchronized, stratum_class.
  output logic [2:0]   m_axis_tuser_o
);

  ntpsws_pkg::cmd_t    cmd;
  ntpsws_pkg::status_t stat;

  ntpsws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ntpsws_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second request taken while busy");
  a_unsync_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o[316:312] == 5'd0))
    else $error("unsynchronized result reports samples");
  a_sync_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |->
    (m_axis_tdata_o[316:312] != 5'd0 && m_axis_tdata_o[316:312] <= 5'd16))
    else $error("synchronized result with bad sample count");
`endif

endmodule

/* design/ntpsws_ctrl.sv */
module ntpsws_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ntpsws_pkg::status_t stat_i,
  output ntpsws_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIFF = 4'd1;
  localparam logic [3:0] ST_PUSH = 4'd2;
  localparam logic [3:0] ST_SUM  = 4'd3;
  localparam logic [3:0] ST_MDIV = 4'd4;
  localparam logic [3:0] ST_SQ   = 4'd5;
  localparam logic [3:0] ST_VDIV = 4'd6;
  localparam logic [3:0] ST_SQRT = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  logic [3:0] state_q, state_d;
  logic [ntpsws_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic sum_last, sq_last;
  logic [ntpsws_pkg::STEP_W:0] sq_end;

  assign sum_last = (cnt_q[ntpsws_pkg::CNT_W-1:0] == stat_i.n - 5'd1);
  assign sq_end   = {stat_i.n, 3'b000} - 8'd1;
  assign sq_last  = (cnt_q == sq_end[ntpsws_pkg::STEP_W-1:0]);
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 7'd1;
    cmd_o   = '0;
    cmd_o.idx = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cnt_d = '0;
        cmd_o.diff = 1'b1;
        state_d = stat_i.sync ? ST_PUSH : ST_DONE;
      end
      ST_PUSH: begin
        cnt_d = '0;
        cmd_o.push = 1'b1;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (sum_last) begin
          cnt_d = '0;
          state_d = ST_MDIV;
        end
      end
      ST_MDIV: begin
        cmd_o.mdiv_step = 1'b1;
        if (cnt_q == 7'(ntpsws_pkg::MDIV_STEPS - 1)) begin
          cnt_d = '0;
          // A single sample has no spread: skip the variance work.
          state_d = (stat_i.n < 5'd2) ? ST_DONE : ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.sq_step = 1'b1;
        if (sq_last) begin
          cnt_d = '0;
          state_d = ST_VDIV;
        end
      end
      ST_VDIV: begin
        cmd_o.vdiv_step = 1'b1;
        if (cnt_q == 7'(ntpsws_pkg::VDIV_STEPS - 1)) begin
          cnt_d = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == 7'(ntpsws_pkg::SQRT_STEPS - 1)) begin
          cnt_d = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        cnt_d = '0;
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.clear  = !stat_i.sync;
          state_d = ST_IDLE;
        end
      end
      default: begin
        cnt_d = '0;
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DIFF))
    else $error("accepted request did not start processing");
  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !stat_i.out_free) |=> (state_q == ST_DONE))
    else $error("result dropped while output was busy");
`endif

endmodule

/* design/ntpsws_dp.sv */
module ntpsws_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ntpsws_pkg::cmd_t    cmd_i,
  output ntpsws_pkg::status_t stat_o,
  input  logic [295:0]        in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [319:0]        out_data_o,
  output logic [2:0]          out_user_o
);

  localparam int unsigned SW = ntpsws_pkg::STAT_W;
  localparam int unsigned MW = ntpsws_pkg::MEAN_W;
  localparam int unsigned AW = ntpsws_pkg::ACC_W;

  logic [63:0] t1_q, t2_q, t3_q, t4_q;
  logic [31:0] rd_q;
  logic [7:0]  strat_q;
  logic [63:0] a_q, b_q, c_q, e_q;

  logic [SW-1:0] off_w [ntpsws_pkg::DEPTH];
  logic [SW-1:0] dly_w [ntpsws_pkg::DEPTH];
  logic [ntpsws_pkg::DISP_W-1:0] disp_w [ntpsws_pkg::DEPTH];

  logic [ntpsws_pkg::CNT_W-1:0]  held_q;
  logic [ntpsws_pkg::SLOT_W-1:0] slot_q;

  logic [MW-1:0] so_q, sd_q, sr_q;
  logic [3:0]    ro_q, rdl_q, rr_q, vro_q, vrd_q;
  logic [AW-1:0] acc_o_q, acc_d_q;
  logic [SW-1:0] doff_q, ddly_q;
  logic [47:0]   prod_q;
  logic [2:0]    psel_q;
  ntpsws_pkg::sqrt_t sq_o_q, sq_d_q;

  logic          out_valid_q;
  logic [319:0]  out_data_q;
  logic [2:0]    out_user_q;

  logic sync;
  logic [1:0] sclass;
  assign sync   = (strat_q >= 8'd1) && (strat_q < 8'd16);
  assign sclass = sync ? ntpsws_pkg::CLASS_SYNC :
                  (strat_q == 8'd0) ? ntpsws_pkg::CLASS_ZERO : ntpsws_pkg::CLASS_BAD;

  assign stat_o.sync     = sync;
  assign stat_o.n        = held_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // Offset and delay magnitudes with saturation to the window width.
  logic signed [65:0] osum, dsum;
  logic [65:0] omag, dmag, ohalf;
  logic [SW-1:0] off_sat, dly_sat;
  assign osum  = 66'(signed'(a_q)) + 66'(signed'(b_q));
  assign dsum  = 66'(signed'(c_q)) - 66'(signed'(e_q));
  assign omag  = osum[65] ? 66'(-osum) : 66'(osum);
  assign dmag  = dsum[65] ? 66'(-dsum) : 66'(dsum);
  assign ohalf = omag >> 1;
  assign off_sat = (ohalf > 66'(ntpsws_pkg::MAX48)) ? ntpsws_pkg::MAX48 : ohalf[SW-1:0];
  assign dly_sat = (dmag  > 66'(ntpsws_pkg::MAX48)) ? ntpsws_pkg::MAX48 : dmag[SW-1:0];

  // Window read port: SUM walks entries by the counter, SQ by its upper bits.
  logic [ntpsws_pkg::SLOT_W-1:0] ridx;
  logic [SW-1:0] off_rd, dly_rd;
  assign ridx   = cmd_i.sq_step ? cmd_i.idx[6:3] : cmd_i.idx[3:0];
  assign off_rd = off_w[ridx];
  assign dly_rd = dly_w[ridx];

  logic [SW-1:0] moff, mdly;
  assign moff = so_q[SW-1:0];
  assign mdly = sd_q[SW-1:0];

  logic [2:0]  sub;
  logic [23:0] ma, mb;
  assign sub = cmd_i.idx[2:0];
  always_comb begin
    case (sub)
      3'd1:    begin ma = doff_q[23:0];  mb = doff_q[23:0]; end
      3'd2:    begin ma = doff_q[47:24]; mb = doff_q[23:0]; end
      3'd3:    begin ma = doff_q[47:24]; mb = doff_q[47:24]; end
      3'd4:    begin ma = ddly_q[23:0];  mb = ddly_q[23:0]; end
      3'd5:    begin ma = ddly_q[47:24]; mb = ddly_q[23:0]; end
      3'd6:    begin ma = ddly_q[47:24]; mb = ddly_q[47:24]; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  logic [AW-1:0] prod_sh;
  always_comb begin
    case (psel_q)
      3'd1, 3'd4: prod_sh = AW'(prod_q);
      3'd2, 3'd5: prod_sh = AW'(prod_q) << 25;
      3'd3, 3'd6: prod_sh = AW'(prod_q) << 48;
      default:    prod_sh = '0;
    endcase
  end

  logic [4:0] q_o, q_d, q_r, vq_o, vq_d, den_m, den_v;
  assign den_m = held_q;
  assign den_v = held_q - 5'd1;
  assign q_o  = ntpsws_pkg::div_step(ro_q,  so_q[MW-1], den_m);
  assign q_d  = ntpsws_pkg::div_step(rdl_q, sd_q[MW-1], den_m);
  assign q_r  = ntpsws_pkg::div_step(rr_q,  sr_q[MW-1], den_m);
  assign vq_o = ntpsws_pkg::div_step(vro_q, acc_o_q[AW-1], den_v);
  assign vq_d = ntpsws_pkg::div_step(vrd_q, acc_d_q[AW-1], den_v);

  ntpsws_pkg::sqrt_t sqn_o, sqn_d;
  assign sqn_o = ntpsws_pkg::sqrt_step(sq_o_q, acc_o_q[AW-1:AW-2]);
  assign sqn_d = ntpsws_pkg::sqrt_step(sq_d_q, acc_d_q[AW-1:AW-2]);

  logic [SW-1:0] spread, jitter, unc;
  logic [SW+1:0] usum;
  logic multi;
  assign multi  = (held_q >= 5'd2);
  assign spread = !multi ? '0 : (sq_d_q.root > ntpsws_pkg::ROOT_W'(ntpsws_pkg::MAX48)) ?
                  ntpsws_pkg::MAX48 : sq_d_q.root[SW-1:0];
  assign jitter = !multi ? '0 : (sq_o_q.root > ntpsws_pkg::ROOT_W'(ntpsws_pkg::MAX48)) ?
                  ntpsws_pkg::MAX48 : sq_o_q.root[SW-1:0];
  assign usum   = (SW+2)'(moff) + (SW+2)'(spread) + (SW+2)'(jitter);
  assign unc    = (usum > (SW+2)'(ntpsws_pkg::MAX48)) ? ntpsws_pkg::MAX48 : usum[SW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      t1_q    <= in_data_i[63:0];
      t2_q    <= in_data_i[127:64];
      t3_q    <= in_data_i[191:128];
      t4_q    <= in_data_i[255:192];
      rd_q    <= in_data_i[287:256];
      strat_q <= in_data_i[295:288];
    end
    if (cmd_i.diff) begin
      a_q <= t2_q - t1_q;
      b_q <= t3_q - t4_q;
      c_q <= t4_q - t1_q;
      e_q <= t3_q - t2_q;
    end
    if (cmd_i.push) begin
      off_w[slot_q]  <= off_sat;
      dly_w[slot_q]  <= dly_sat;
      disp_w[slot_q] <= rd_q;
      so_q <= '0; sd_q <= '0; sr_q <= '0;
      ro_q <= '0; rdl_q <= '0; rr_q <= '0; vro_q <= '0; vrd_q <= '0;
      acc_o_q <= '0; acc_d_q <= '0;
      psel_q  <= '0;
      sq_o_q  <= '0; sq_d_q <= '0;
    end
    if (cmd_i.sum_step) begin
      so_q <= so_q + MW'(off_rd);
      sd_q <= sd_q + MW'(dly_rd);
      sr_q <= sr_q + MW'(disp_w[ridx]);
    end
    if (cmd_i.mdiv_step) begin
      so_q <= {so_q[MW-2:0], q_o[4]};  ro_q  <= q_o[3:0];
      sd_q <= {sd_q[MW-2:0], q_d[4]};  rdl_q <= q_d[3:0];
      sr_q <= {sr_q[MW-2:0], q_r[4]};  rr_q  <= q_r[3:0];
    end
    if (cmd_i.sq_step) begin
      if (sub == 3'd0) begin
        doff_q <= (off_rd >= moff) ? off_rd - moff : moff - off_rd;
        ddly_q <= (dly_rd >= mdly) ? dly_rd - mdly : mdly - dly_rd;
      end
      prod_q <= ma * mb;
      psel_q <= sub;
      if (psel_q >= 3'd1 && psel_q <= 3'd3) begin
        acc_o_q <= acc_o_q + prod_sh;
      end
      if (psel_q >= 3'd4 && psel_q <= 3'd6) begin
        acc_d_q <= acc_d_q + prod_sh;
      end
    end
    if (cmd_i.vdiv_step) begin
      acc_o_q <= {acc_o_q[AW-2:0], vq_o[4]};  vro_q <= vq_o[3:0];
      acc_d_q <= {acc_d_q[AW-2:0], vq_d[4]};  vrd_q <= vq_d[3:0];
    end
    if (cmd_i.sqrt_step) begin
      acc_o_q <= acc_o_q << 2;
      acc_d_q <= acc_d_q << 2;
      sq_o_q  <= sqn_o;
      sq_d_q  <= sqn_d;
    end
    if (cmd_i.finish) begin
      out_user_q <= {sclass, sync};
      if (sync) begin
        out_data_q <= {3'b000, held_q, unc, jitter, spread, sr_q[31:0], mdly, moff,
                       t3_q[63:32], strat_q};
      end else begin
        out_data_q <= {280'd0, t3_q[63:32], strat_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        slot_q <= slot_q + 4'd1;
        if (held_q < 5'(ntpsws_pkg::DEPTH)) begin
          held_q <= held_q + 5'd1;
        end
      end
      if (cmd_i.clear) begin
        held_q <= '0;
        slot_q <= '0;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

`ifndef ASSERT_OFF
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= 5'(ntpsws_pkg::DEPTH))
    else $error("sample count beyond window depth");
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (held_q == '0 && slot_q == '0))
    else $error("window not emptied");
`endif

endmodule
